FILE: rtl/chrl_pkg.sv
package chrl_pkg;

   localparam int FUNC_W  = 1;
   localparam int INDEX_W = 10;
   localparam int POINT_W = 32;
   localparam int KEY_W   = 32;
   localparam int POS_W   = 10;
   localparam int COUNT_W = 11;

   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 1'b1;

   // status of one search step, from the step unit to the sequencer
   typedef struct packed {
      logic hit;
      logic bounds_crossed;
      logic mid_past_end;
   } step_flags_type;

endpackage

FILE: rtl/chrl_ring_mem.sv
module chrl_ring_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [chrl_pkg::POINT_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [chrl_pkg::POINT_W-1:0] rd_data
);
   import chrl_pkg::*;

   logic [POINT_W-1:0] mem_array [DEPTH];
   logic [POINT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/chrl_step_unit.sv
module chrl_step_unit #(
   parameter int IW = 13
) (
   input  logic                          eval,
   input  logic [chrl_pkg::KEY_W-1:0]    key,
   input  logic [chrl_pkg::POINT_W-1:0]  here,
   input  logic [chrl_pkg::POINT_W-1:0]  prior_point,
   input  logic signed [IW-1:0]          low,
   input  logic signed [IW-1:0]          high,
   input  logic signed [IW-1:0]          mid,
   input  logic signed [IW-1:0]          size,
   output logic signed [IW-1:0]          low_next,
   output logic signed [IW-1:0]          high_next,
   output logic signed [IW-1:0]          mid_next,
   output chrl_pkg::step_flags_type      flags
);
   import chrl_pkg::*;

   logic              key_above;
   logic signed [IW-1:0] sum;

   assign key_above = here < key;

   always_comb begin
      low_next  = low;
      high_next = high;
      if (eval) begin
         if (key_above) begin
            low_next = mid + IW'(1);
         end else begin
            high_next = mid - IW'(1);
         end
      end
   end

   assign sum      = low_next + high_next;
   assign mid_next = sum >>> 1;

   assign flags.hit            = eval && (key <= here) && (key > prior_point);
   assign flags.bounds_crossed = eval && (low_next > high_next);
   assign flags.mid_past_end   = mid_next >= size;

endmodule

FILE: rtl/consistent_hash_ring_lookup_unit.sv
// a lookup runs a binary search of at most floor(log2(count+1))+1 steps, then returns rsp_valid
// a lookup holds the input until its response is registered; the point table has a single
// read port, so each step reads point[mid] and point[mid-1] in turn
// write transactions complete in the cycle they are accepted and give no response
// one transaction in flight; the next is accepted while a response waits on rsp_stall
// synchronous active-high reset clears control and the count; table contents are kept
module consistent_hash_ring_lookup_unit #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [chrl_pkg::FUNC_W-1:0]   req_func,
   input  logic [chrl_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic [chrl_pkg::POINT_W-1:0]  req_point_value,
   input  logic [chrl_pkg::KEY_W-1:0]    req_lookup_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [chrl_pkg::POS_W-1:0]    rsp_ring_position,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [chrl_pkg::COUNT_W-1:0]  csr_entries_in_use
);
   import chrl_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int IW = $clog2(RING_DEPTH + 1) + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MID,
      ST_FETCH,
      ST_EVAL,
      ST_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [POINT_W-1:0]    here_ff, here_in;
   logic signed [IW-1:0]  low_ff, low_in;
   logic signed [IW-1:0]  high_ff, high_in;
   logic signed [IW-1:0]  mid_ff, mid_in;
   logic signed [IW-1:0]  size_ff, size_in;
   logic [POS_W-1:0]      result_ff, result_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;

   logic                  accept;
   logic                  slot_ok;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [POINT_W-1:0]    rd_data;
   logic [POINT_W-1:0]    prior_point;
   logic                  step_eval;
   logic signed [IW-1:0]  size_sat;
   logic signed [IW-1:0]  mid_less;
   logic signed [IW-1:0]  low_next, high_next, mid_next;
   step_flags_type        flags;
   logic                  out_free;
   logic                  finish;
   logic [POS_W-1:0]      finish_pos;
   logic [31:0]           mid_wide;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign slot_ok = 32'(req_entry_index) < 32'(RING_DEPTH);
   assign wr_en   = accept && (req_func == FUNC_WRITE) && slot_ok;
   assign wr_addr = AW'(req_entry_index);

   assign size_sat = (32'(count_ff) > 32'(RING_DEPTH)) ? IW'(RING_DEPTH) : IW'(count_ff);

   assign mid_less    = mid_ff - IW'(1);
   assign prior_point = (mid_ff == '0) ? '0 : rd_data;
   assign step_eval   = state_ff == ST_EVAL;
   assign mid_wide    = 32'($unsigned(mid_ff));

   chrl_ring_mem #(
      .DEPTH (RING_DEPTH),
      .AW    (AW)
   ) u_ring_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_point_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   chrl_step_unit #(
      .IW (IW)
   ) u_step_unit (
      .eval        (step_eval),
      .key         (key_ff),
      .here        (here_ff),
      .prior_point (prior_point),
      .low         (low_ff),
      .high        (high_ff),
      .mid         (mid_ff),
      .size        (size_ff),
      .low_next    (low_next),
      .high_next   (high_next),
      .mid_next    (mid_next),
      .flags       (flags)
   );

   always_comb begin
      // mid-1 in the fetch cycle, the next mid otherwise
      if (state_ff == ST_FETCH) begin
         rd_addr = (mid_ff == '0) ? '0 : mid_less[AW-1:0];
      end else begin
         rd_addr = mid_next[AW-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      key_in       = key_ff;
      here_in      = here_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mid_in       = mid_ff;
      size_in      = size_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      finish       = 1'b0;
      finish_pos   = '0;

      if (csr_valid && csr_ready) begin
         count_in = csr_entries_in_use;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_func == FUNC_LOOKUP)) begin
               key_in   = req_lookup_key;
               low_in   = '0;
               high_in  = size_sat;
               size_in  = size_sat;
               state_in = ST_MID;
            end
         end
         ST_MID: begin
            low_in  = low_next;
            high_in = high_next;
            mid_in  = mid_next;
            if (flags.mid_past_end) begin
               finish = 1'b1;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            here_in  = rd_data;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (flags.hit) begin
               finish     = 1'b1;
               finish_pos = mid_wide[POS_W-1:0];
            end else if (flags.bounds_crossed || flags.mid_past_end) begin
               finish = 1'b1;
            end else begin
               low_in   = low_next;
               high_in  = high_next;
               mid_in   = mid_next;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         result_in = finish_pos;
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = finish_pos;
            state_in     = ST_IDLE;
         end else begin
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff     <= key_in;
      here_ff    <= here_in;
      low_ff     <= low_in;
      high_ff    <= high_in;
      mid_ff     <= mid_in;
      size_ff    <= size_in;
      result_ff  <= result_in;
      rsp_pos_ff <= rsp_pos_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ring_position = rsp_pos_ff;

   a_mid_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (mid_ff >= 0) && (mid_ff < size_ff))
      else $error("search reads outside the populated ring");

   a_mid_between_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH || state_ff == ST_EVAL) |-> (low_ff <= mid_ff) && (mid_ff <= high_ff))
      else $error("mid left the search bounds");

   a_lookup_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_LOOKUP)) |=> (state_ff == ST_MID) && (low_ff == 0))
      else $error("lookup transaction did not start a search");

   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FUNC_WRITE)) |=> (state_ff == ST_IDLE))
      else $error("write transaction started a search");

endmodule
